// ===== rtl/ddo_pkg.sv =====
// Package: shared types, constants and tables for the odometry block.
package ddo_pkg;

  localparam int unsigned DefCordicSteps = 24;
  localparam int unsigned MaxCordicSteps = 32;
  localparam logic [31:0] WheelBaseReset = 32'd65536;
  localparam logic [31:0] AngScale       = 32'd683565276;
  localparam logic [31:0] CordicGain     = 32'd652032874;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic signed [32:0] d0;
    logic signed [32:0] d1;
    logic               straight;
  } ddo_item_t;

  // CORDIC arctangent table, Q32 binary angle.
  function automatic logic [31:0] atan_tab(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ddo_if.sv =====
// Interfaces: valid/ready channels for wheel items, pose items and config writes.
interface ddo_wheel_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] wheel_a_pos;
  logic signed [31:0] wheel_b_pos;
  modport source (output valid, wheel_a_pos, wheel_b_pos, input ready);
  modport sink (input valid, wheel_a_pos, wheel_b_pos, output ready);
endinterface

interface ddo_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic        [31:0] pose_heading;
  logic               went_straight;
  modport source (output valid, pose_x, pose_y, pose_heading, went_straight, input ready);
  modport sink (input valid, pose_x, pose_y, pose_heading, went_straight, output ready);
endinterface

interface ddo_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/differential_drive_odometry.sv =====
// Top level: differential-drive odometry with wheel, pose and config channels.
// Usage:
//   wheel  - sink of absolute wheel positions (Q16.16); one item per update.
//   pose   - source of the updated pose x, y (Q16.16, saturating), heading
//            (binary angle, 2^32 per turn) and the went_straight flag.
//   cfg    - write channel for wheel_base (unsigned Q16.16); write while idle.
// Work per item: a straight item takes one CORDIC run; a turn below
//   resolution takes one divider pass (phi) and one CORDIC run; a turning
//   item takes three passes of the divider (phi, dx, dy) and two CORDIC
//   runs. The shared bit-serial divider sets the rate.
// Throughput: the back part works on one item at a time and pops the next the
//   cycle after it loads the output register, so items are spaced by latency.
// A two-item queue between front and back lets the wheel side keep handing
//   items while the back part is busy; deltas are formed at acceptance.
// Reset: pose and stored wheel positions clear to zero, wheel_base to 1.0.
// Stall: a held pose item waits in the output register; the back part stops
//   at its final state and the queue fills, then wheel.ready drops.
module differential_drive_odometry #(
  parameter int unsigned CORDIC_STEPS = ddo_pkg::DefCordicSteps
) (
  input  logic       clk,
  input  logic       rst,
  ddo_wheel_if.sink  wheel,
  ddo_pose_if.source pose,
  ddo_cfg_if.sink    cfg
);
  import ddo_pkg::*;

  logic [31:0] wheel_base;
  ddo_item_t   q_item;
  logic        q_valid, q_pop;

  // Config register, always ready.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) wheel_base <= WheelBaseReset;
    else if (cfg.valid) wheel_base <= cfg.data;
  end

  ddo_front u_front (.clk, .rst, .wheel, .q_item, .q_valid, .q_pop);

  ddo_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (.clk, .rst, .q_item, .q_valid,
    .q_pop, .wheel_base, .pose);

  // Queue pop only when something is queued.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  // Held pose item keeps y, heading and flag.
  a_hold_fields: assert property (@(posedge clk) disable iff (rst)
    (pose.valid && !pose.ready) |=>
    ($stable(pose.pose_y) && $stable(pose.pose_heading) && $stable(pose.went_straight)))
    else $error("pose fields changed under stall");
  // Output item holds while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (pose.valid && !pose.ready) |=> (pose.valid && $stable(pose.pose_x)))
    else $error("pose dropped under stall");
endmodule

// ===== rtl/ddo_divider.sv =====
// Module: signed restoring divider, one quotient bit per cycle, truncating.
module ddo_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic signed [63:0] divisor,
  output logic               done,
  output logic signed [63:0] quotient
);
  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic [6:0]  cnt;
  logic        neg;
  logic        busy;
  logic [64:0] trial;

  assign trial = {rem[63:0], quo[63]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // pulse after the last quotient bit
      done <= !start && busy && (cnt == 7'd63);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        rem  <= 64'd0;
        quo  <= dividend[63] ? 64'(-dividend) : dividend;
        dvs  <= divisor[63] ? 64'(-divisor) : divisor;
        neg  <= dividend[63] ^ divisor[63];
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = neg ? 64'(-quo) : quo;
endmodule

// ===== rtl/ddo_cordic.sv =====
// Module: iterative rotation-mode CORDIC, sine and cosine in Q2.30.
module ddo_cordic #(
  parameter int unsigned CORDIC_STEPS = ddo_pkg::DefCordicSteps
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [33:0] sin_out,
  output logic signed [33:0] cos_out
);
  import ddo_pkg::*;
  localparam int unsigned CntW = $clog2(CORDIC_STEPS + 1);

  logic signed [33:0] x, y;
  logic signed [33:0] z;
  logic               flip;
  logic               busy;
  logic [CntW-1:0]    cnt;
  logic signed [33:0] zs, xs, ys;
  logic [4:0]         idx;

  assign idx = 5'(cnt);
  assign xs = x >>> idx;
  assign ys = y >>> idx;
  assign zs = {{2{angle[31]}}, angle};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // pulse after the last iteration
      done <= !start && busy && (cnt == CntW'(CORDIC_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        x    <= 34'(CordicGain);
        y    <= '0;
        if (zs > 34'sd1073741824) begin
          z <= zs - 34'sd2147483648; flip <= 1'b1;
        end else if (zs < -34'sd1073741824) begin
          z <= zs + 34'sd2147483648; flip <= 1'b1;
        end else begin
          z <= zs; flip <= 1'b0;
        end
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - ys; y <= y + xs; z <= z - 34'(atan_tab(idx));
        end else begin
          x <= x + ys; y <= y - xs; z <= z + 34'(atan_tab(idx));
        end
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign sin_out = flip ? -y : y;
  assign cos_out = flip ? -x : x;
endmodule

// ===== rtl/ddo_front.sv =====
// Module: front part; takes wheel items, forms deltas, queues classified items.
module ddo_front (
  input  logic              clk,
  input  logic              rst,
  ddo_wheel_if.sink         wheel,
  output ddo_pkg::ddo_item_t q_item,
  output logic              q_valid,
  input  logic              q_pop
);
  import ddo_pkg::*;
  localparam int unsigned Depth = 2;

  ddo_item_t          mem [Depth];
  logic               wp, rp;
  logic [1:0]         cnt;
  logic signed [31:0] last_a, last_b;
  ddo_item_t          it;
  logic               push;

  assign wheel.ready = (cnt != 2'(Depth));
  assign push = wheel.valid && wheel.ready;
  assign it.d0 = 33'(wheel.wheel_a_pos) - 33'(last_a);
  assign it.d1 = 33'(wheel.wheel_b_pos) - 33'(last_b);
  assign it.straight = (it.d0 == it.d1);

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= it;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0; last_a <= '0; last_b <= '0;
    end else begin
      if (push) begin
        wp <= ~wp; last_a <= wheel.wheel_a_pos; last_b <= wheel.wheel_b_pos;
      end
      if (q_pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

  assign q_valid = (cnt != 2'd0);
  assign q_item  = mem[rp];
endmodule

// ===== rtl/ddo_back.sv =====
// Module: back part; arc motion, pose composition and the output register.
module ddo_back #(
  parameter int unsigned CORDIC_STEPS = ddo_pkg::DefCordicSteps
) (
  input  logic               clk,
  input  logic               rst,
  input  ddo_pkg::ddo_item_t q_item,
  input  logic               q_valid,
  output logic               q_pop,
  input  logic [31:0]        wheel_base,
  ddo_pose_if.source         pose
);
  import ddo_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_PHI   = 12'b000000000010,
    S_DTH   = 12'b000000000100,
    S_CS1   = 12'b000000001000,
    S_MUL1  = 12'b000000010000,
    S_DIVX  = 12'b000000100000,
    S_DIVY  = 12'b000001000000,
    S_CS2   = 12'b000010000000,
    S_ROT1  = 12'b000100000000,
    S_ROT2  = 12'b001000000000,
    S_SUM   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } st_t;

  st_t st;
  logic               sub;
  ddo_item_t          cur;
  logic signed [33:0] sum;
  logic signed [63:0] phi;
  logic [31:0]        dth;
  logic signed [63:0] dx, dy, px, py;
  logic signed [33:0] s28, c28;
  logic signed [31:0] x, y;
  logic [31:0]        hd;
  logic signed [63:0] div_a, div_b, div_q;
  logic               div_go, div_done;
  logic               cs_go, cs_done;
  logic [31:0]        cs_ang;
  logic signed [33:0] cs_s, cs_c;
  logic signed [63:0] ta, tb;
  logic signed [63:0] nx, ny;
  logic [55:0]        pm_lo;
  logic [27:0]        pm_hi;
  logic [55:0]        pm;
  logic signed [33:0] dxc, dyc;

  ddo_divider u_div (.clk, .rst, .start(div_go), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q));
  ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cs (.clk, .rst, .start(cs_go),
    .angle(cs_ang), .done(cs_done), .sin_out(cs_s), .cos_out(cs_c));

  function automatic logic signed [33:0] clamp33(input logic signed [63:0] v);
    if (v > 64'sd4294967296) return 34'sd4294967296;
    if (v < -64'sd4294967296) return -34'sd4294967296;
    return 34'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  // Division by 32, truncating toward zero.
  function automatic logic signed [63:0] div32(input logic signed [63:0] v);
    return (v + (v[63] ? 64'sd31 : 64'sd0)) >>> 5;
  endfunction

  // phi * AngScale modulo 2^56, from two registered partial products
  assign pm  = pm_lo + {pm_hi, 28'd0};
  assign dxc = clamp33(dx);
  assign dyc = clamp33(dy);
  assign nx  = 64'(x) + ((px + 64'sd536870912) >>> 30);
  assign ny  = 64'(y) + ((py + 64'sd536870912) >>> 30);

  assign q_pop = (st == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; pose.valid <= 1'b0; x <= '0; y <= '0; hd <= '0;
      div_go <= 1'b0; cs_go <= 1'b0; sub <= 1'b0;
    end else begin
      // start strobes last one cycle; no state raises one while it is high
      if (div_go) div_go <= 1'b0;
      if (cs_go) cs_go <= 1'b0;
      if (pose.valid && pose.ready && st != S_OUT) pose.valid <= 1'b0;
      case (st)
        S_IDLE: if (q_valid) begin
          cur <= q_item;
          sum <= 34'(q_item.d0) + 34'(q_item.d1);
          dth <= '0; dy <= '0;
          if (q_item.straight) begin
            dx <= 64'(q_item.d0); cs_ang <= hd; cs_go <= 1'b1; st <= S_CS2;
          end else begin
            div_a <= 64'(34'(q_item.d0) - 34'(q_item.d1)) <<< 24;
            div_b <= (wheel_base == 32'd0) ? 64'sd1 : 64'($unsigned(wheel_base));
            div_go <= 1'b1; sub <= 1'b0; st <= S_PHI;
          end
        end
        S_PHI: if (div_done) begin
          phi <= div_q;
          if (div_q == 64'sd0) begin
            // half the sum, truncated toward zero
            dx <= (64'(sum) + $signed({63'd0, sum[33]})) >>> 1;
            cs_ang <= hd; cs_go <= 1'b1; st <= S_CS2;
          end else st <= S_DTH;
        end
        S_DTH: if (!sub) begin
          pm_lo <= 56'(phi[27:0]) * 56'(AngScale);
          pm_hi <= phi[55:28] * AngScale[27:0];
          sub <= 1'b1;
        end else begin
          dth <= pm[55:24]; cs_ang <= pm[55:24]; cs_go <= 1'b1;
          sub <= 1'b0; st <= S_CS1;
        end
        S_CS1: if (cs_done) begin
          s28 <= cs_s >>> 2;
          c28 <= 34'sd268435456 - (cs_c >>> 2);
          st <= S_MUL1;
        end
        S_MUL1: begin
          ta <= 64'(sum) * 64'(s28);
          tb <= 64'(sum) * 64'(c28);
          div_a <= 64'(sum) * 64'(s28); div_b <= phi; div_go <= 1'b1;
          st <= S_DIVX;
        end
        S_DIVX: if (div_done) begin
          dx <= div32(div_q); div_a <= tb; div_b <= phi; div_go <= 1'b1;
          st <= S_DIVY;
        end
        S_DIVY: if (div_done) begin
          dy <= div32(div_q); cs_ang <= hd; cs_go <= 1'b1; st <= S_CS2;
        end
        S_CS2: if (cs_done) begin
          ta <= 64'(cs_c) * 64'(dxc);
          tb <= 64'(cs_s) * 64'(dyc);
          st <= S_ROT1;
        end
        S_ROT1: begin
          px <= ta - tb;
          ta <= 64'(cs_s) * 64'(dxc);
          tb <= 64'(cs_c) * 64'(dyc);
          st <= S_ROT2;
        end
        S_ROT2: begin
          py <= ta + tb; st <= S_SUM;
        end
        S_SUM: begin
          x <= sat32(nx); y <= sat32(ny); hd <= hd + dth; st <= S_OUT;
        end
        S_OUT: if (!pose.valid || pose.ready) begin
          pose.valid <= 1'b1;
          pose.pose_x <= x; pose.pose_y <= y; pose.pose_heading <= hd;
          pose.went_straight <= cur.straight;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== tb/differential_drive_odometry_tb.sv =====
// Testbench for differential_drive_odometry: directed table plus random wheel items.
module differential_drive_odometry_tb;
  import ddo_pkg::*;

  // One pose item as the block reports it.
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [31:0] heading;
    logic               straight;
  } pose_t;

  // Directed row: wheel positions, plus a typed pose where it is obvious.
  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    bit          typed;
    pose_t       pose;
  } wheel_row_t;

  localparam int unsigned Steps     = DefCordicSteps;
  localparam int          HoldCycles = 1500;
  localparam int          DrainWait  = 600;

  logic clk;
  logic rst;

  ddo_wheel_if wheel ();
  ddo_pose_if  pose ();
  ddo_cfg_if   cfg ();

  differential_drive_odometry dut (
    .clk   (clk),
    .rst   (rst),
    .wheel (wheel),
    .pose  (pose),
    .cfg   (cfg)
  );

  always #1 clk = ~clk;

  // Predictor state: odometry copy of the block's registers.
  logic [31:0] odo_base;
  longint      odo_last_a;
  longint      odo_last_b;
  longint      odo_x;
  longint      odo_y;
  logic [31:0] odo_heading;

  pose_t pending_poses[$];   // poses still owed by the block
  pose_t typed_poses[$];     // hand-typed poses, checked alongside the predictor
  bit    typed_valid[$];

  int  mismatches;
  int  poses_seen;
  int  turns_sent;
  int  straights_sent;
  bit  no_idle;        // stretch with no gaps on either side
  bit  hold_request;   // ask the pose side for a long hold-off
  bit  hold_done;

  // Arithmetic shift right on a 64-bit signed value.
  function automatic longint shr(input longint v, input int n);
    return v >>> n;
  endfunction

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp33(input longint v);
    longint lim;
    lim = 64'sd1 << 32;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Rotation-mode CORDIC on a binary angle; sine and cosine in Q2.30.
  function automatic void cordic_sin_cos(input logic [31:0] ang, output longint s,
                                         output longint c);
    longint z, x, y, xs, ys, quarter;
    bit     flip;
    z = longint'({32'b0, ang});
    x = longint'(CordicGain);
    y = 0;
    quarter = 64'sd1 << 30;
    flip = 0;
    if (z >= (64'sd1 << 31)) z -= 64'sd1 << 32;
    if (z > quarter || z < -quarter) begin
      z += (z > 0) ? -(64'sd1 << 31) : (64'sd1 << 31);
      flip = 1;
    end
    for (int i = 0; i < Steps && i < 32; i++) begin
      xs = shr(x, i);
      ys = shr(y, i);
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= longint'({32'b0, atan_tab(5'(i))});
      end else begin
        x += ys;
        y -= xs;
        z += longint'({32'b0, atan_tab(5'(i))});
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  // Advance the odometry by one pair of wheel positions and return the new pose.
  function automatic pose_t odometry_update(input logic [31:0] a_pos, input logic [31:0] b_pos);
    longint a, b, d0, d1, sum, diff, dx, dy, s, c, rx, ry, w, phi_r;
    logic [63:0] prod;
    logic [31:0] dtheta;
    pose_t p;
    a = longint'(signed'(a_pos));
    b = longint'(signed'(b_pos));
    d0 = a - odo_last_a;
    d1 = b - odo_last_b;
    sum = d0 + d1;
    diff = d0 - d1;
    dtheta = '0;
    p.straight = 0;
    odo_last_a = a;
    odo_last_b = b;
    if (diff == 0) begin
      dx = d0;
      dy = 0;
      p.straight = 1;
    end else begin
      w = (odo_base != 0) ? longint'({32'b0, odo_base}) : 1;
      phi_r = (diff * 64'sd16777216) / w;
      if (phi_r == 0) begin
        // turn below resolution: half the sum, no heading change
        dx = sum / 2;
        dy = 0;
      end else begin
        prod = 64'(phi_r) * 64'(AngScale);
        dtheta = prod[55:24];
        cordic_sin_cos(dtheta, s, c);
        s = shr(s, 2);
        c = (64'sd1 << 28) - shr(c, 2);
        dx = (sum * s) / phi_r / 32;
        dy = (sum * c) / phi_r / 32;
      end
    end
    dx = clamp33(dx);
    dy = clamp33(dy);
    cordic_sin_cos(odo_heading, s, c);
    rx = c * dx - s * dy;
    ry = s * dx + c * dy;
    odo_x = sat32(odo_x + shr(rx + (64'sd1 << 29), 30));
    odo_y = sat32(odo_y + shr(ry + (64'sd1 << 29), 30));
    odo_heading = odo_heading + dtheta;
    p.x = odo_x[31:0];
    p.y = odo_y[31:0];
    p.heading = odo_heading;
    return p;
  endfunction

  function automatic int idle_gap();
    if (no_idle || $urandom_range(99) >= 16) return 0;
    return $urandom_range(1, 5);
  endfunction

  // Offer one wheel item; the valid stays high if no gap precedes the next one.
  task automatic send_wheels(input logic [31:0] a, input logic [31:0] b,
                             input bit typed, input pose_t typed_pose);
    int gap;
    pose_t p;
    gap = idle_gap();
    if (gap > 0) begin
      wheel.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    wheel.valid       <= 1'b1;
    wheel.wheel_a_pos <= a;
    wheel.wheel_b_pos <= b;
    @(posedge clk);
    while (!wheel.ready) @(posedge clk);
    p = odometry_update(a, b);
    if (p.straight) straights_sent++;
    else turns_sent++;
    pending_poses = {pending_poses, p};
    typed_poses = {typed_poses, typed_pose};
    typed_valid = {typed_valid, typed};
  endtask

  // Write wheel_base; waits until nothing is in flight before writing.
  task automatic write_wheel_base(input logic [31:0] value);
    wheel.valid <= 1'b0;
    wait (pending_poses.size() == 0);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    odo_base = value;
  endtask

  function automatic void report_mismatch(input string what, input pose_t exp, input pose_t act);
    mismatches++;
    if (mismatches <= 10)
      $display("pose %0d %s: expected x=%h y=%h hd=%h st=%b, got x=%h y=%h hd=%h st=%b",
               poses_seen, what, exp.x, exp.y, exp.heading, exp.straight,
               act.x, act.y, act.heading, act.straight);
  endfunction

  // Pose side: random stalls, one long hold-off on request, field-wise check.
  initial begin
    pose_t act, exp, typed_pose;
    bit typed;
    pose.ready <= 1'b0;
    hold_done = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (pose.valid && pose.ready) begin
        act.x = pose.pose_x;
        act.y = pose.pose_y;
        act.heading = pose.pose_heading;
        act.straight = pose.went_straight;
        poses_seen++;
        if (pending_poses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("pose %0d arrived with nothing owed", poses_seen);
        end else begin
          exp = pending_poses.pop_front();
          typed_pose = typed_poses.pop_front();
          typed = typed_valid.pop_front();
          if (act.x !== exp.x || act.y !== exp.y || act.heading !== exp.heading ||
              act.straight !== exp.straight)
            report_mismatch("vs predictor", exp, act);
          else if (typed && (act.x !== typed_pose.x || act.y !== typed_pose.y ||
                   act.heading !== typed_pose.heading || act.straight !== typed_pose.straight))
            report_mismatch("vs table", typed_pose, act);
        end
      end
      if (hold_request && !hold_done) begin
        // long hold-off: the block queue fills and wheel.ready must drop
        pose.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_done = 1;
      end else begin
        pose.ready <= (no_idle || $urandom_range(99) >= 16);
      end
    end
  end

  // Run limit: far above the slowest legal run.
  initial begin
    #12000000;
    $display("timeout with %0d poses owed", pending_poses.size());
    $display("CHECK FAILED");
    $finish;
  end

  wheel_row_t table_rows[$];
  logic [31:0] base_plan[$];

  initial begin
    pose_t none, zero_pose;
    logic [31:0] a, b, da, db;
    int mode, shift, phase_items;
    clk = 1'b0;
    rst <= 1'b1;
    wheel.valid <= 1'b0;
    wheel.wheel_a_pos <= '0;
    wheel.wheel_b_pos <= '0;
    cfg.valid <= 1'b0;
    cfg.data <= '0;
    mismatches = 0;
    poses_seen = 0;
    turns_sent = 0;
    straights_sent = 0;
    no_idle = 0;
    hold_request = 0;
    none = '{default: '0};
    zero_pose = '{x: '0, y: '0, heading: '0, straight: 1'b1};
    odo_base = WheelBaseReset;
    odo_last_a = 0;
    odo_last_b = 0;
    odo_x = 0;
    odo_y = 0;
    odo_heading = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: no motion from reset, extremes, straight runs and turns.
    table_rows = '{
      '{32'h0000_0000, 32'h0000_0000, 1, zero_pose},
      '{32'h0000_0000, 32'h0000_0000, 1, zero_pose},
      '{32'h0001_0000, 32'h0001_0000, 0, none},
      '{32'hFFFF_0000, 32'hFFFF_0000, 0, none},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, none},
      '{32'h8000_0000, 32'h8000_0000, 0, none},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, none},
      '{32'h0000_0000, 32'h0000_0000, 0, none},
      '{32'h0000_0001, 32'h0000_0000, 0, none},
      '{32'h0000_0001, 32'h0000_0001, 0, none},
      '{32'h0001_0000, 32'h0000_0000, 0, none},
      '{32'h0001_0000, 32'h0001_0000, 0, none},
      '{32'h0000_0064, 32'hFFFF_FF9C, 0, none},
      '{32'h0003_0000, 32'h0001_0000, 0, none},
      '{32'h7FFF_FFFF, 32'h8000_0000, 0, none},
      '{32'h8000_0000, 32'h7FFF_FFFF, 0, none},
      '{32'h0000_0000, 32'hFFFF_FFFF, 0, none},
      '{32'h0006_4800, 32'hFFF9_B800, 0, none},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, none},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, none},
      '{32'h8000_0000, 32'h8000_0000, 0, none},
      '{32'h5555_5555, 32'hAAAA_AAAA, 0, none},
      '{32'hAAAA_AAAA, 32'h5555_5555, 0, none}
    };
    write_wheel_base(WheelBaseReset);
    foreach (table_rows[i])
      send_wheels(table_rows[i].a, table_rows[i].b, table_rows[i].typed, table_rows[i].pose);

    // Random phases across wheel_base settings, the extremes among them.
    base_plan = '{32'h0001_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
                  32'h0002_8000, 32'h0000_4000, 32'h0100_0000};
    base_plan = {base_plan, 32'($urandom())};
    a = wheel.wheel_a_pos;
    b = wheel.wheel_b_pos;
    foreach (base_plan[ph]) begin
      write_wheel_base(base_plan[ph]);
      no_idle = (ph == 1);
      phase_items = 200;
      for (int n = 0; n < phase_items; n++) begin
        if (ph == 2 && n == 20) hold_request = 1;
        if (ph == 3 && n == 100) begin
          // sender pause until every owed pose is back
          wheel.valid <= 1'b0;
          wait (pending_poses.size() == 0);
          @(posedge clk);
        end
        mode = $urandom_range(99);
        shift = $urandom_range(0, 24);
        da = $urandom() >> (31 - shift);
        da = $urandom_range(1) ? -da : da;
        db = $urandom() >> (31 - $urandom_range(0, 24));
        db = $urandom_range(1) ? -db : db;
        if (mode < 45) begin
          a = a + da;
          b = b + db;
        end else if (mode < 62) begin
          a = a + da;
          b = b + da;
        end else if (mode < 78) begin
          // tiny difference: below resolution at wide wheel bases
          a = a + da;
          b = b + da + $urandom_range(1, 3) * ($urandom_range(1) ? 1 : -1);
        end else begin
          a = $urandom();
          b = $urandom();
        end
        send_wheels(a, b, 0, none);
      end
    end
    wheel.valid <= 1'b0;
    no_idle = 0;

    wait (pending_poses.size() == 0);
    repeat (DrainWait) @(posedge clk);
    if (pending_poses.size() != 0) mismatches++;
    $display("covered %0d poses (%0d turning, %0d straight) over %0d wheel_base values",
             poses_seen, turns_sent, straights_sent, base_plan.size() + 1);
    $display("with a %0d-cycle pose hold-off and %0d mismatches", HoldCycles, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
